### hw/rtl/scld_pkg.sv
// ----------------------------------------------------------------------------
// scld_pkg - shared definitions for the serial command line decoder
// Transaction types, character and command codes, and keyword/reply tables.
// ----------------------------------------------------------------------------
package scld_pkg;

	localparam int LINE_BYTES_DEF = 64;
	localparam logic [15:0] STALE_RESET = 16'd500;

	localparam int KW_COUNT = 11;

	localparam logic [3:0] CMD_FACE      = 4'd0;
	localparam logic [3:0] CMD_MSG       = 4'd1;
	localparam logic [3:0] CMD_WEATHER   = 4'd2;
	localparam logic [3:0] CMD_TIME      = 4'd3;
	localparam logic [3:0] CMD_THEME     = 4'd4;
	localparam logic [3:0] CMD_SOUND     = 4'd5;
	localparam logic [3:0] CMD_SCANLINES = 4'd6;
	localparam logic [3:0] CMD_NOTIFY    = 4'd7;
	localparam logic [3:0] CMD_STATS     = 4'd8;
	localparam logic [3:0] CMD_AISTATS   = 4'd9;
	localparam logic [3:0] CMD_PING      = 4'd10;

	localparam logic [1:0] KIND_CMD   = 2'd0;
	localparam logic [1:0] KIND_ARG   = 2'd1;
	localparam logic [1:0] KIND_REPLY = 2'd2;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;

	localparam logic [2:0] REPLY_LAST = 3'd7;

	typedef struct packed {
		logic [7:0]  byte_value;
		logic [31:0] now_ms;
	} rx_item_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [3:0] command_code;
		logic [7:0] data_byte;
		logic       last_of_run;
	} res_item_t;

	typedef struct packed {
		logic [3:0] code;
		logic       is_ping;
		logic       bank;
	} line_desc_t;

	typedef struct packed {
		logic valid;
		logic bank;
	} bank_rel_t;

	function automatic logic [3:0] kw_len(input logic [3:0] k);
		logic [3:0] n;
		case (k)
			CMD_FACE:      n = 4'd4;
			CMD_MSG:       n = 4'd3;
			CMD_WEATHER:   n = 4'd7;
			CMD_TIME:      n = 4'd4;
			CMD_THEME:     n = 4'd5;
			CMD_SOUND:     n = 4'd5;
			CMD_SCANLINES: n = 4'd9;
			CMD_NOTIFY:    n = 4'd6;
			CMD_STATS:     n = 4'd5;
			CMD_AISTATS:   n = 4'd7;
			CMD_PING:      n = 4'd4;
			default:       n = 4'd0;
		endcase
		return n;
	endfunction

	// Keyword text is left-justified: element 8 holds the first character.
	function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [3:0] p);
		logic [8:0][7:0] s;
		s = '0;
		case (k)
			CMD_FACE:      s = {"FACE", 40'd0};
			CMD_MSG:       s = {"MSG", 48'd0};
			CMD_WEATHER:   s = {"WEATHER", 16'd0};
			CMD_TIME:      s = {"TIME", 40'd0};
			CMD_THEME:     s = {"THEME", 32'd0};
			CMD_SOUND:     s = {"SOUND", 32'd0};
			CMD_SCANLINES: s = "SCANLINES";
			CMD_NOTIFY:    s = {"NOTIFY", 24'd0};
			CMD_STATS:     s = {"STATS", 32'd0};
			CMD_AISTATS:   s = {"AISTATS", 16'd0};
			CMD_PING:      s = {"PING", 40'd0};
			default:       s = '0;
		endcase
		return (p <= 4'd8) ? s[4'd8 - p] : CH_NUL;
	endfunction

	// Identity reply sent after the ping command code.
	function automatic logic [7:0] reply_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = 8'h4D;
			3'd1:    c = 8'h49;
			3'd2:    c = 8'h4D;
			3'd3:    c = 8'h4F;
			3'd4:    c = CH_SPACE;
			3'd5:    c = 8'h31;
			3'd6:    c = CH_CR;
			default: c = CH_LF;
		endcase
		return c;
	endfunction

endpackage

### hw/rtl/scld_line_mem.sv
// ----------------------------------------------------------------------------
// scld_line_mem - double-buffered line store
// Two banks of line bytes, one write port and one registered read port.
// ----------------------------------------------------------------------------
module scld_line_mem #(
	parameter int LINE_BYTES = scld_pkg::LINE_BYTES_DEF,
	localparam int AW = $clog2(2 * LINE_BYTES)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [2*LINE_BYTES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/scld_queue.sv
// ----------------------------------------------------------------------------
// scld_queue - two-entry line descriptor queue
// Carries classified lines from the front end to the back end.
// ----------------------------------------------------------------------------
module scld_queue #(
	parameter int LINE_BYTES = scld_pkg::LINE_BYTES_DEF,
	localparam int LW = $clog2(LINE_BYTES)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  scld_pkg::line_desc_t push_desc,
	input  logic [LW-1:0]        push_start,
	input  logic [LW-1:0]        push_end,
	input  logic                 pop,
	output logic                 empty,
	output logic                 full,
	output scld_pkg::line_desc_t head_desc,
	output logic [LW-1:0]        head_start,
	output logic [LW-1:0]        head_end
);

	scld_pkg::line_desc_t desc_q [2];
	logic [LW-1:0]        start_q [2];
	logic [LW-1:0]        end_q [2];
	logic                 wp_q;
	logic                 rp_q;
	logic [1:0]           cnt_q;

	logic do_push;
	logic do_pop;

	assign empty   = (cnt_q == 2'd0);
	assign full    = (cnt_q == 2'd2);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	assign head_desc  = desc_q[rp_q];
	assign head_start = start_q[rp_q];
	assign head_end   = end_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= !wp_q;
			end
			if (do_pop) begin
				rp_q <= !rp_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			desc_q[wp_q]  <= push_desc;
			start_q[wp_q] <= push_start;
			end_q[wp_q]   <= push_end;
		end
	end

endmodule

### hw/rtl/scld_front.sv
// ----------------------------------------------------------------------------
// scld_front - byte intake and line classification
// Applies the stale timeout, stores bytes, tracks the keyword match as the
// line arrives and queues a descriptor for every recognized line.
// ----------------------------------------------------------------------------
module scld_front #(
	parameter int LINE_BYTES = scld_pkg::LINE_BYTES_DEF,
	localparam int LW = $clog2(LINE_BYTES),
	localparam int AW = $clog2(2 * LINE_BYTES)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [15:0]           cfg_wdata,
	input  logic                  rx_valid,
	output logic                  rx_stall,
	input  scld_pkg::rx_item_t    rx_data,
	output logic                  push,
	output scld_pkg::line_desc_t  push_desc,
	output logic [LW-1:0]         push_start,
	output logic [LW-1:0]         push_end,
	input  scld_pkg::bank_rel_t   rel,
	output logic                  mem_we,
	output logic [AW-1:0]         mem_waddr,
	output logic [7:0]            mem_wdata
);

	localparam int KWC = scld_pkg::KW_COUNT;

	logic [15:0]     timeout_q;
	logic [31:0]     last_q;
	logic [LW-1:0]   len_q;
	logic [LW-1:0]   eff_q;
	logic [LW-1:0]   cmd_q;
	logic            zero_q;
	logic            space_q;
	logic            hash_q;
	logic [KWC-1:0]  match_q;
	logic            bank_q;
	logic [1:0]      busy_q;

	logic            accept;
	logic [31:0]     gap;
	logic            stale;
	logic [7:0]      c;
	logic            is_lf;
	logic            is_cr;
	logic [LW-1:0]   cur_len;
	logic [LW-1:0]   cur_eff;
	logic [LW-1:0]   cur_cmd;
	logic            cur_zero;
	logic            cur_space;
	logic            cur_hash;
	logic [KWC-1:0]  cur_match;
	logic            store;
	logic            content;
	logic            in_cmd;
	logic [KWC-1:0]  match_nx;
	logic [LW-1:0]   cmd_len;
	logic            found;
	logic [3:0]      code;
	logic [1:0]      busy_nx;

	assign accept   = rx_valid && !rx_stall;
	assign rx_stall = busy_q[bank_q];
	assign c        = rx_data.byte_value;
	assign is_lf    = (c == scld_pkg::CH_LF);
	assign is_cr    = (c == scld_pkg::CH_CR);

	// A partial line is thrown away before this byte is looked at.
	assign gap   = rx_data.now_ms - last_q;
	assign stale = (len_q != '0) && (gap > {16'd0, timeout_q});

	assign cur_len   = stale ? '0 : len_q;
	assign cur_eff   = stale ? '0 : eff_q;
	assign cur_cmd   = stale ? '0 : cmd_q;
	assign cur_zero  = stale ? 1'b0 : zero_q;
	assign cur_space = stale ? 1'b0 : space_q;
	assign cur_hash  = stale ? 1'b0 : hash_q;
	assign cur_match = stale ? '1 : match_q;

	assign store   = accept && !is_lf && !is_cr && (cur_len < LW'(LINE_BYTES - 1));
	assign content = !cur_zero && (c != scld_pkg::CH_NUL);
	assign in_cmd  = content && !cur_space && (c != scld_pkg::CH_SPACE);

	always_comb begin
		for (int k = 0; k < KWC; k++) begin
			match_nx[k] = cur_match[k] && (!in_cmd ||
				((cur_len < LW'(scld_pkg::kw_len(4'(k)))) &&
				 (scld_pkg::kw_char(4'(k), cur_len[3:0]) == c)));
		end
	end

	assign cmd_len = cur_space ? cur_cmd : cur_eff;

	always_comb begin
		found = 1'b0;
		code  = scld_pkg::CMD_FACE;
		for (int k = KWC - 1; k >= 0; k--) begin
			if (cur_match[k] && (LW'(scld_pkg::kw_len(4'(k))) == cmd_len)) begin
				found = 1'b1;
				code  = 4'(k);
			end
		end
		if ((cur_eff == '0) || cur_hash) begin
			found = 1'b0;
		end
	end

	assign push              = accept && is_lf && found;
	assign push_desc.code    = code;
	assign push_desc.is_ping = (code == scld_pkg::CMD_PING);
	assign push_desc.bank    = bank_q;
	assign push_start        = cur_space ? LW'({1'b0, cur_cmd} + 1'b1) : cur_eff;
	assign push_end          = cur_eff;

	assign mem_we    = store;
	assign mem_waddr = bank_q ? (AW'(LINE_BYTES) + AW'(cur_len)) : AW'(cur_len);
	assign mem_wdata = c;

	always_comb begin
		busy_nx = busy_q;
		if (rel.valid) begin
			busy_nx[rel.bank] = 1'b0;
		end
		if (push) begin
			busy_nx[bank_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= scld_pkg::STALE_RESET;
			last_q    <= '0;
			len_q     <= '0;
			eff_q     <= '0;
			cmd_q     <= '0;
			zero_q    <= 1'b0;
			space_q   <= 1'b0;
			hash_q    <= 1'b0;
			match_q   <= '1;
			bank_q    <= 1'b0;
			busy_q    <= '0;
		end else begin
			busy_q <= busy_nx;
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (accept) begin
				last_q <= rx_data.now_ms;
				if (is_lf) begin
					len_q   <= '0;
					eff_q   <= '0;
					cmd_q   <= '0;
					zero_q  <= 1'b0;
					space_q <= 1'b0;
					hash_q  <= 1'b0;
					match_q <= '1;
					if (push) begin
						bank_q <= !bank_q;
					end
				end else if (store) begin
					len_q   <= cur_len + 1'b1;
					eff_q   <= content ? cur_eff + 1'b1 : cur_eff;
					cmd_q   <= (content && !cur_space && (c == scld_pkg::CH_SPACE))
						? cur_len : cur_cmd;
					space_q <= cur_space || (content && (c == scld_pkg::CH_SPACE));
					zero_q  <= cur_zero || (c == scld_pkg::CH_NUL);
					hash_q  <= cur_hash || ((cur_len == '0) && (c == scld_pkg::CH_HASH));
					match_q <= match_nx;
				end else begin
					// CR or a dropped byte still lets a stale line go.
					len_q   <= cur_len;
					eff_q   <= cur_eff;
					cmd_q   <= cur_cmd;
					zero_q  <= cur_zero;
					space_q <= cur_space;
					hash_q  <= cur_hash;
					match_q <= cur_match;
				end
			end
		end
	end

endmodule

### hw/rtl/scld_back.sv
// ----------------------------------------------------------------------------
// scld_back - result sequencer
// Pops line descriptors and emits the command code followed by argument
// bytes read from the line store, or by the identity reply.
// ----------------------------------------------------------------------------
module scld_back #(
	parameter int LINE_BYTES = scld_pkg::LINE_BYTES_DEF,
	localparam int LW = $clog2(LINE_BYTES),
	localparam int AW = $clog2(2 * LINE_BYTES)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  scld_pkg::line_desc_t q_desc,
	input  logic [LW-1:0]        q_start,
	input  logic [LW-1:0]        q_end,
	output logic                 pop,
	output scld_pkg::bank_rel_t  rel,
	output logic                 mem_re,
	output logic [AW-1:0]        mem_raddr,
	input  logic [7:0]           mem_rdata,
	output logic                 res_valid,
	input  logic                 res_stall,
	output scld_pkg::res_item_t  res_data
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_RD    = 2'd1;
	localparam logic [1:0] S_WR    = 2'd2;
	localparam logic [1:0] S_REPLY = 2'd3;

	logic [1:0]          state_q;
	logic [LW-1:0]       ptr_q;
	logic [LW-1:0]       end_q;
	logic [3:0]          code_q;
	logic                bank_q;
	logic [2:0]          idx_q;
	logic                out_valid_q;
	scld_pkg::res_item_t out_q;

	logic [1:0]          state_nx;
	logic [LW-1:0]       ptr_nx;
	logic [2:0]          idx_nx;
	logic                out_free;
	logic                load;
	scld_pkg::res_item_t item;
	logic [LW:0]         ptr_inc;

	assign out_free  = !out_valid_q || !res_stall;
	assign res_valid = out_valid_q;
	assign res_data  = out_q;
	assign ptr_inc   = {1'b0, ptr_q} + 1'b1;
	assign mem_raddr = bank_q ? (AW'(LINE_BYTES) + AW'(ptr_q)) : AW'(ptr_q);

	always_comb begin
		state_nx  = state_q;
		ptr_nx    = ptr_q;
		idx_nx    = idx_q;
		pop       = 1'b0;
		rel.valid = 1'b0;
		rel.bank  = bank_q;
		mem_re    = 1'b0;
		load      = 1'b0;
		item      = '0;
		case (state_q)
			S_IDLE: begin
				if (!q_empty && out_free) begin
					pop               = 1'b1;
					load              = 1'b1;
					item.result_kind  = scld_pkg::KIND_CMD;
					item.command_code = q_desc.code;
					rel.bank          = q_desc.bank;
					if (q_desc.is_ping) begin
						// The reply needs no line bytes, so the bank goes back now.
						rel.valid = 1'b1;
						idx_nx    = '0;
						state_nx  = S_REPLY;
					end else if (q_start >= q_end) begin
						item.last_of_run = 1'b1;
						rel.valid        = 1'b1;
					end else begin
						ptr_nx   = q_start;
						state_nx = S_RD;
					end
				end
			end
			S_RD: begin
				mem_re   = 1'b1;
				state_nx = S_WR;
			end
			S_WR: begin
				if (out_free) begin
					load              = 1'b1;
					item.result_kind  = scld_pkg::KIND_ARG;
					item.command_code = code_q;
					item.data_byte    = mem_rdata;
					item.last_of_run  = (ptr_inc == {1'b0, end_q});
					ptr_nx            = LW'(ptr_inc);
					if (item.last_of_run) begin
						rel.valid = 1'b1;
						state_nx  = S_IDLE;
					end else begin
						state_nx = S_RD;
					end
				end
			end
			S_REPLY: begin
				if (out_free) begin
					load              = 1'b1;
					item.result_kind  = scld_pkg::KIND_REPLY;
					item.command_code = code_q;
					item.data_byte    = scld_pkg::reply_char(idx_q);
					item.last_of_run  = (idx_q == scld_pkg::REPLY_LAST);
					idx_nx            = idx_q + 3'd1;
					if (item.last_of_run) begin
						state_nx = S_IDLE;
					end
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ptr_q       <= '0;
			end_q       <= '0;
			code_q      <= '0;
			bank_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			ptr_q   <= ptr_nx;
			idx_q   <= idx_nx;
			if (pop) begin
				end_q  <= q_end;
				code_q <= q_desc.code;
				bank_q <= q_desc.bank;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= item;
		end
	end

endmodule

### hw/rtl/serial_command_line_decoder_core.sv
// ----------------------------------------------------------------------------
// serial_command_line_decoder_core - serial command line decoder
// Front end takes one byte per cycle; the back end emits the results of each
// recognized line from the other bank of a double-buffered line store.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, held off only while the bank the front end
//   would write next still holds a line the back end has not finished reading.
// Results: the command code is loaded straight from the queue head, each argument
//   byte takes a line store read then an output load, reply bytes every cycle while res_stall is low.
// The first result of a line is registered in the queue, then in the output register.
// Reset clears all control state; the line store is not cleared.
module serial_command_line_decoder_core #(
	parameter int LINE_BYTES = scld_pkg::LINE_BYTES_DEF,
	localparam int LW = $clog2(LINE_BYTES),
	localparam int AW = $clog2(2 * LINE_BYTES)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata,
	input  logic                rx_valid,
	output logic                rx_stall,
	input  scld_pkg::rx_item_t  rx_data,
	output logic                res_valid,
	input  logic                res_stall,
	output scld_pkg::res_item_t res_data
);

	logic                 q_push;
	scld_pkg::line_desc_t q_push_desc;
	logic [LW-1:0]        q_push_start;
	logic [LW-1:0]        q_push_end;
	logic                 q_pop;
	logic                 q_empty;
	logic                 q_full;
	scld_pkg::line_desc_t q_head_desc;
	logic [LW-1:0]        q_head_start;
	logic [LW-1:0]        q_head_end;
	scld_pkg::bank_rel_t  rel;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [7:0]           mem_wdata;
	logic                 mem_re;
	logic [AW-1:0]        mem_raddr;
	logic [7:0]           mem_rdata;

	scld_front #(.LINE_BYTES(LINE_BYTES)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.rx_valid   (rx_valid),
		.rx_stall   (rx_stall),
		.rx_data    (rx_data),
		.push       (q_push),
		.push_desc  (q_push_desc),
		.push_start (q_push_start),
		.push_end   (q_push_end),
		.rel        (rel),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata)
	);

	scld_queue #(.LINE_BYTES(LINE_BYTES)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_desc  (q_push_desc),
		.push_start (q_push_start),
		.push_end   (q_push_end),
		.pop        (q_pop),
		.empty      (q_empty),
		.full       (q_full),
		.head_desc  (q_head_desc),
		.head_start (q_head_start),
		.head_end   (q_head_end)
	);

	scld_line_mem #(.LINE_BYTES(LINE_BYTES)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	scld_back #(.LINE_BYTES(LINE_BYTES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_desc    (q_head_desc),
		.q_start   (q_head_start),
		.q_end     (q_head_end),
		.pop       (q_pop),
		.rel       (rel),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	// Bank bookkeeping must keep the queue from ever overflowing.
	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("line queue pushed while full");

	// The front end never writes the bank the back end is reading.
	a_bank_separation: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |->
		((mem_waddr >= AW'(LINE_BYTES)) != (mem_raddr >= AW'(LINE_BYTES))))
		else $error("line store write and read hit the same bank");

	// A descriptor is only taken when one is waiting.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("back end popped an empty queue");

endmodule

### verif/scld_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scld_result_checker - result predictor and scoreboard for the line decoder
// Watches the byte, configuration and result channels, rebuilds each text line
// as it is received and compares every result transaction in order.
// ----------------------------------------------------------------------------
module scld_result_checker
	import scld_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        rx_valid,
	input  logic        rx_stall,
	input  rx_item_t    rx_data,
	input  logic        res_valid,
	input  logic        res_stall,
	input  res_item_t   res_data,
	output int          fail_count,
	output int          results_due,
	output int          results_checked
);

	localparam int LINE_CAP = LINE_BYTES_DEF;

	// Indexed by command code.
	string keyword_of [KW_COUNT] = '{"FACE", "MSG", "WEATHER", "TIME", "THEME", "SOUND",
		"SCANLINES", "NOTIFY", "STATS", "AISTATS", "PING"};
	// Identity reply text, ending in CR LF.
	logic [7:0] ident_reply [8] = '{8'h4D, 8'h49, 8'h4D, 8'h4F, CH_SPACE, 8'h31, CH_CR, CH_LF};

	logic [7:0]  line_buf [LINE_CAP];
	int          line_len;
	logic [31:0] last_ms;
	logic [15:0] stale_limit;
	res_item_t   line_results_q[$];
	int          fails;
	int          checked;

	task automatic predict_rx_byte(input logic [7:0] value, input logic [31:0] stamp);
		int          len;
		int          word_len;
		int          start;
		int          code;
		int          i;
		int          k;
		bit          spaced;
		bit          same;
		string       w;
		logic [31:0] gap;
		res_item_t   r;
		gap = stamp - last_ms;
		if (line_len > 0 && gap > 32'(stale_limit))
			line_len = 0;
		last_ms = stamp;
		if (value == CH_LF) begin
			len = 0;
			while (len < line_len && line_buf[len] != CH_NUL)
				len++;
			code = -1;
			spaced = 1'b0;
			word_len = len;
			if (len > 0 && line_buf[0] != CH_HASH) begin
				for (i = 0; i < len && !spaced; i++) begin
					if (line_buf[i] == CH_SPACE) begin
						word_len = i;
						spaced = 1'b1;
					end
				end
				for (k = 0; k < KW_COUNT && code < 0; k++) begin
					w = keyword_of[k];
					same = (w.len() == word_len);
					for (i = 0; same && i < word_len; i++)
						same = (line_buf[i] == w[i]);
					if (same)
						code = k;
				end
			end
			if (code >= 0) begin
				r.result_kind = KIND_CMD;
				r.command_code = code[3:0];
				r.data_byte = '0;
				if (r.command_code == CMD_PING) begin
					r.last_of_run = 1'b0;
					line_results_q.push_back(r);
					for (i = 0; i < $size(ident_reply); i++) begin
						r.result_kind = KIND_REPLY;
						r.data_byte = ident_reply[i];
						r.last_of_run = (i == $size(ident_reply) - 1);
						line_results_q.push_back(r);
					end
				end else begin
					start = spaced ? word_len + 1 : len;
					r.last_of_run = (start >= len);
					line_results_q.push_back(r);
					for (i = start; i < len; i++) begin
						r.result_kind = KIND_ARG;
						r.data_byte = line_buf[i];
						r.last_of_run = (i + 1 == len);
						line_results_q.push_back(r);
					end
				end
			end
			line_len = 0;
		end else if (value != CH_CR && line_len < LINE_CAP - 1) begin
			line_buf[line_len] = value;
			line_len++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		res_item_t want;
		if (!arst_n) begin
			line_len = 0;
			last_ms = '0;
			stale_limit = STALE_RESET;
			line_results_q.delete();
			fails = 0;
			checked = 0;
			fail_count <= 0;
			results_due <= 0;
			results_checked <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (line_results_q.size() == 0) begin
					$error("unexpected result: kind %0d code %0d data %02h last %0d",
						res_data.result_kind, res_data.command_code, res_data.data_byte,
						res_data.last_of_run);
					fails++;
				end else begin
					want = line_results_q.pop_front();
					checked++;
					if (res_data.result_kind !== want.result_kind) begin
						$error("result_kind: expected %0d, got %0d", want.result_kind,
							res_data.result_kind);
						fails++;
					end
					if (res_data.command_code !== want.command_code) begin
						$error("command_code: expected %0d, got %0d", want.command_code,
							res_data.command_code);
						fails++;
					end
					if (res_data.data_byte !== want.data_byte) begin
						$error("data_byte: expected %02h, got %02h", want.data_byte,
							res_data.data_byte);
						fails++;
					end
					if (res_data.last_of_run !== want.last_of_run) begin
						$error("last_of_run: expected %0d, got %0d", want.last_of_run,
							res_data.last_of_run);
						fails++;
					end
				end
			end
			if (rx_valid && !rx_stall)
				predict_rx_byte(rx_data.byte_value, rx_data.now_ms);
			if (cfg_we)
				stale_limit = cfg_wdata;
			fail_count <= fails;
			results_due <= line_results_q.size();
			results_checked <= checked;
		end
	end

endmodule

### verif/serial_command_line_decoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_line_decoder_core_tb - testbench for the line decoder core
// Sends directed and random text lines with millisecond stamps under several
// stale-timeout settings and random stalls; a checker module scores results.
// ----------------------------------------------------------------------------
module serial_command_line_decoder_core_tb;
	import scld_pkg::*;

	localparam int SETTLE_CYCLES  = 3 * LINE_BYTES_DEF;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_BYTES   = 300;
	localparam int PHASES         = 6;

	typedef enum int {PACE_STEADY, PACE_EDGE, PACE_GLITCH, PACE_WILD} pace_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        rx_valid;
	logic        rx_stall;
	rx_item_t    rx_data;
	logic        res_valid;
	logic        res_stall = 1'b0;
	res_item_t   res_data;
	int          fail_count;
	int          results_due;
	int          results_checked;

	// Indexed by command code.
	string keyword_of [KW_COUNT] = '{"FACE", "MSG", "WEATHER", "TIME", "THEME", "SOUND",
		"SCANLINES", "NOTIFY", "STATS", "AISTATS", "PING"};

	logic [7:0]  line_q[$];
	logic [31:0] now_cursor;
	logic [15:0] stale_setting;
	int          rx_gap_max;
	int          res_gap_max;
	int          res_hold = 0;
	int          idle_cycles = 0;
	int          bytes_sent;
	int          lines_sent;
	int          settings_used;

	always #1 clk = ~clk;

	serial_command_line_decoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rx_valid  (rx_valid),
		.rx_stall  (rx_stall),
		.rx_data   (rx_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	scld_result_checker chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.rx_valid        (rx_valid),
		.rx_stall        (rx_stall),
		.rx_data         (rx_data),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.res_data        (res_data),
		.fail_count      (fail_count),
		.results_due     (results_due),
		.results_checked (results_checked)
	);

	// After each result transaction the receiver stalls for a random number of cycles.
	always @(posedge clk) begin : res_pacing
		int g;
		if (res_hold > 0) begin
			res_hold <= res_hold - 1;
			res_stall <= (res_hold > 1);
		end else if (res_valid && !res_stall) begin
			g = $urandom_range(0, res_gap_max);
			res_hold <= g;
			res_stall <= (g > 0);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (rx_valid && !rx_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("serial_command_line_decoder_core_tb: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_byte(input logic [7:0] value, input logic [31:0] stamp);
		int gap;
		gap = $urandom_range(0, rx_gap_max);
		if (gap > 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_data <= '{byte_value: value, now_ms: stamp};
		@(posedge clk);
		while (rx_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_line(input pace_t pace, input int glitch_at);
		int          i;
		logic [31:0] step;
		for (i = 0; i < line_q.size(); i++) begin
			case (pace)
				PACE_STEADY: step = $urandom_range(0, (stale_setting < 3) ? stale_setting : 3);
				// A gap equal to the timeout still keeps the partial line.
				PACE_EDGE:   step = 32'(stale_setting);
				PACE_GLITCH: step = (i == glitch_at) ? 32'(stale_setting) + 32'd1 : 32'd0;
				default: begin
					now_cursor = $urandom;
					step = 32'd0;
				end
			endcase
			now_cursor += step;
			send_byte(line_q[i], now_cursor);
		end
		lines_sent++;
	endtask

	task automatic load_text(input string s);
		int i;
		line_q.delete();
		for (i = 0; i < s.len(); i++)
			line_q.push_back(s[i]);
	endtask

	task automatic compose_line();
		int shape;
		int n;
		int i;
		shape = $urandom_range(0, 19);
		load_text(keyword_of[$urandom_range(0, KW_COUNT - 1)]);
		if (shape < 15) begin
			if (shape >= 13) begin
				// Near miss of a keyword.
				case ($urandom_range(0, 2))
					0: begin
						i = $urandom_range(0, line_q.size() - 1);
						line_q[i] = line_q[i] ^ (8'h01 << $urandom_range(0, 7));
					end
					1: void'(line_q.pop_back());
					default: line_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
				endcase
			end
			if ($urandom_range(0, 3) != 0) begin
				line_q.push_back(CH_SPACE);
				n = (shape == 0) ? $urandom_range(50, 70) : $urandom_range(0, 8);
				repeat (n)
					line_q.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
						: 8'($urandom_range(8'h20, 8'h7E)));
			end
		end else if (shape == 15) begin
			line_q.delete();
			line_q.push_back(CH_HASH);
			repeat ($urandom_range(0, 6))
				line_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
		end else if (shape == 16) begin
			line_q.delete();
			if ($urandom_range(0, 1) != 0)
				line_q.push_back(CH_CR);
		end else begin
			line_q.delete();
			repeat ($urandom_range(1, 12))
				line_q.push_back(8'($urandom_range(0, 255)));
		end
		// Now and then the terminator is lost and the line runs into the next one.
		if ($urandom_range(0, 15) != 0)
			line_q.push_back(CH_LF);
	endtask

	task automatic drain(input bit settle);
		rx_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
		if (settle)
			repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_stale_timeout(input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		stale_setting = value;
		settings_used++;
	endtask

	initial begin
		int          phase;
		int          phase_end;
		int          pace_pick;
		logic [15:0] stale_plan [PHASES];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		rx_valid = 1'b0;
		rx_data = '0;
		bytes_sent = 0;
		lines_sent = 0;
		settings_used = 1;
		stale_setting = STALE_RESET;
		now_cursor = 32'hFFFF_FFFC;
		rx_gap_max = 8;
		res_gap_max = 8;
		stale_plan = '{16'hFFFF, 16'd0, 16'd3, 16'($urandom_range(4, 65534)), 16'd1, STALE_RESET};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// PING with an argument and a CR: the argument is dropped and the reply follows.
		load_text("PING 1");
		line_q.push_back(CH_CR);
		line_q.push_back(CH_LF);
		send_line(PACE_STEADY, 0);
		load_text("#");
		line_q.push_back(CH_LF);
		send_line(PACE_STEADY, 0);
		load_text("");
		line_q.push_back(CH_LF);
		send_line(PACE_STEADY, 0);
		load_text("MSG");
		line_q.push_back(CH_LF);
		send_line(PACE_STEADY, 0);
		// The zero byte ends the content, leaving a keyword with an empty argument.
		load_text("TIME ");
		line_q.push_back(CH_NUL);
		line_q.push_back(8'hFF);
		line_q.push_back(CH_LF);
		send_line(PACE_STEADY, 0);
		// The leading byte goes stale, so the rest still decodes as a keyword.
		load_text("QFACE");
		line_q.push_back(CH_LF);
		send_line(PACE_GLITCH, 1);

		for (phase = 0; phase < PHASES; phase++) begin
			drain(1'b1);
			write_stale_timeout(stale_plan[phase]);
			rx_gap_max = (phase == 1 || phase == 4) ? 0 : 8;
			res_gap_max = (phase == 2 || phase == 4) ? 0 : 8;
			phase_end = bytes_sent + RANDOM_BYTES / PHASES;
			while (bytes_sent < phase_end) begin
				compose_line();
				pace_pick = $urandom_range(0, 15);
				if (pace_pick < 11)
					send_line(PACE_STEADY, 0);
				else if (pace_pick < 13)
					send_line(PACE_EDGE, 0);
				else if (pace_pick < 15)
					send_line(PACE_GLITCH, $urandom_range(1, 8));
				else
					send_line(PACE_WILD, 0);
				if ($urandom_range(0, 9) == 0)
					drain(1'b0);
			end
		end
		drain(1'b1);

		$display("Run covered %0d bytes in %0d lines under %0d stale-timeout settings.",
			bytes_sent, lines_sent, settings_used);
		$display("%0d decoded results were checked, with and without stalls on both sides.",
			results_checked);
		if (fail_count == 0 && results_due == 0)
			$display("serial_command_line_decoder_core_tb: PASS");
		else
			$display("serial_command_line_decoder_core_tb: FAIL");
		$finish;
	end

endmodule
